// ===== rtl/tbfr_pkg.sv =====
// Package for the two-border flood reach engine: item and result words, opcodes,
// configuration register indexes and default grid limits. No dependencies.
`timescale 1ns / 1ps

package tbfr_pkg;

	localparam int MAX_ROWS_DEF    = 32;
	localparam int MAX_COLS_DEF    = 32;
	localparam int HEIGHT_BITS_DEF = 16;

	localparam int COUNT_W   = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 6;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SOLVE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [4:0]  row;
		logic [4:0]  col;
		logic [15:0] height;
	} item_t;

	typedef struct packed {
		logic [31:0]        row_mask;
		logic [COUNT_W-1:0] both_count;
	} result_t;

endpackage

// ===== rtl/two_border_flood_reach_top.sv =====
// Top level of the two-border flood reach engine: height memory, two reach maps,
// work queue and the sequencer that runs both floods. Depends on tbfr_pkg.
`timescale 1ns / 1ps

// A load word writes one cell height (saturated to HEIGHT_BITS) and gives no
// result. A read word returns the row's mask of cells reached by both floods: the
// row is read from both reach maps, masked in S_READ and sent from S_EMIT once the
// result port is free. A solve word first clears both reach maps, one row a cycle
// over all MAX_ROWS rows, then runs the top/left flood and the bottom/right flood
// in turn. Each flood seeds every cell of its two borders through a seed and a
// check step, and dequeues each cell it reaches through the pop, here and height
// wait steps, then takes each in-bounds neighbour through a neighbour and a check
// step. The height memory and the reach maps, each read once per cycle, set the
// pace. The block takes no new word while a solve or read is in progress; loads
// may stream while an earlier result waits on the result port. The count of cells
// reached by both floods is accumulated while the second flood marks cells, so no
// sweep is needed at the end. After reset the block clears both reach maps, one row
// a cycle, and stalls its input until the clear is done. Configuration writes are
// accepted at any time and take effect at the next solve.
module two_border_flood_reach_top #(
	parameter int MAX_ROWS    = tbfr_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS    = tbfr_pkg::MAX_COLS_DEF,
	parameter int HEIGHT_BITS = tbfr_pkg::HEIGHT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  tbfr_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output tbfr_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tbfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tbfr_pkg::CFG_W-1:0]     cfg_data
);

	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int RDIM_W = $clog2(MAX_ROWS + 1);
	localparam int CDIM_W = $clog2(MAX_COLS + 1);
	localparam int SIDX_W = (RDIM_W > CDIM_W) ? RDIM_W : CDIM_W;
	localparam int MASK_N = (MAX_COLS < 32) ? MAX_COLS : 32;
	localparam int CNT_W  = tbfr_pkg::COUNT_W;
	localparam int CFG_W_L = tbfr_pkg::CFG_W;
	localparam logic [HEIGHT_BITS-1:0] HMAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_SEED  = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_POP   = 4'd4;
	localparam logic [3:0] S_HERE  = 4'd5;
	localparam logic [3:0] S_HWAIT = 4'd6;
	localparam logic [3:0] S_NBR   = 4'd7;
	localparam logic [3:0] S_READ  = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;

	// Memories.
	logic [HEIGHT_BITS-1:0] height_mem [DEPTH];
	logic [MAX_COLS-1:0]    tl_mem [MAX_ROWS];
	logic [MAX_COLS-1:0]    br_mem [MAX_ROWS];
	logic [ADDR_W-1:0]      queue_mem [DEPTH];

	logic [HEIGHT_BITS-1:0] h_rd_q;
	logic [MAX_COLS-1:0]    tl_rd_q, br_rd_q;
	logic [ADDR_W-1:0]      q_rd_q;

	// Control and working registers.
	logic [3:0]        state_q;
	logic [CFG_W_L-1:0] rows_cfg_q, cols_cfg_q;
	logic [RDIM_W-1:0] nr_q;
	logic [CDIM_W-1:0] nc_q;
	logic [ROW_W-1:0]  clr_q;
	logic              boot_q;
	logic              flood_q, seeding_q, seed_phase_q;
	logic [SIDX_W-1:0] seed_idx_q;
	logic [ADDR_W:0]   head_q, tail_q;
	logic [ROW_W-1:0]  cur_r_q, tgt_r_q;
	logic [COL_W-1:0]  cur_c_q, tgt_c_q;
	logic [HEIGHT_BITS-1:0] here_h_q;
	logic [1:0]        dir_q;
	logic [CNT_W-1:0]  count_q;
	logic              rd_ok_q;
	logic [31:0]       mask_q;
	logic              out_valid_q;
	tbfr_pkg::result_t out_q;

	// Combinational addressing.
	logic              take;
	logic [ADDR_W-1:0] h_raddr;
	logic [ROW_W-1:0]  vis_raddr;
	logic [ROW_W-1:0]  seed_r;
	logic [COL_W-1:0]  seed_c;
	logic [ROW_W-1:0]  nbr_r;
	logic [COL_W-1:0]  nbr_c;
	logic              nbr_ok;
	logic              load_ok, read_ok;
	logic [HEIGHT_BITS-1:0] load_h;
	logic [RDIM_W-1:0] nr_new;
	logic [CDIM_W-1:0] nc_new;
	logic [MAX_COLS-1:0] own_row, own_row_set;
	logic              own_bit, mark;
	logic [31:0]       mask_c;
	logic              out_free;

	assign item_stall = (state_q != S_IDLE);
	assign take       = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || !result_stall;

	assign load_ok = (32'(item.row) < MAX_ROWS) && (32'(item.col) < MAX_COLS);
	assign read_ok = (32'(item.row) < MAX_ROWS);
	assign load_h  = (32'(item.height) > 32'(HMAX)) ? HMAX : HEIGHT_BITS'(item.height);

	// Register values out of range are clamped into 1..MAX.
	always_comb begin
		if (rows_cfg_q == '0) begin
			nr_new = RDIM_W'(1);
		end else if (32'(rows_cfg_q) > MAX_ROWS) begin
			nr_new = RDIM_W'(MAX_ROWS);
		end else begin
			nr_new = RDIM_W'(rows_cfg_q);
		end
		if (cols_cfg_q == '0) begin
			nc_new = CDIM_W'(1);
		end else if (32'(cols_cfg_q) > MAX_COLS) begin
			nc_new = CDIM_W'(MAX_COLS);
		end else begin
			nc_new = CDIM_W'(cols_cfg_q);
		end
	end

	// The first flood seeds the top row then the left column; the second the
	// bottom row then the right column.
	always_comb begin
		if (!seed_phase_q) begin
			seed_r = flood_q ? ROW_W'(nr_q - RDIM_W'(1)) : '0;
			seed_c = COL_W'(seed_idx_q);
		end else begin
			seed_r = ROW_W'(seed_idx_q);
			seed_c = flood_q ? COL_W'(nc_q - CDIM_W'(1)) : '0;
		end
	end

	always_comb begin
		nbr_r  = cur_r_q;
		nbr_c  = cur_c_q;
		nbr_ok = 1'b0;
		case (dir_q)
			2'd0: begin
				nbr_r  = cur_r_q - ROW_W'(1);
				nbr_ok = (cur_r_q != '0);
			end
			2'd1: begin
				nbr_c  = cur_c_q - COL_W'(1);
				nbr_ok = (cur_c_q != '0);
			end
			2'd2: begin
				nbr_r  = cur_r_q + ROW_W'(1);
				nbr_ok = (32'(cur_r_q) + 1 < 32'(nr_q));
			end
			default: begin
				nbr_c  = cur_c_q + COL_W'(1);
				nbr_ok = (32'(cur_c_q) + 1 < 32'(nc_q));
			end
		endcase
	end

	always_comb begin
		h_raddr   = {nbr_r, nbr_c};
		vis_raddr = nbr_r;
		unique case (state_q)
			S_IDLE: begin
				vis_raddr = ROW_W'(item.row);
			end
			S_SEED: begin
				vis_raddr = seed_r;
			end
			S_HERE: begin
				h_raddr = q_rd_q;
			end
			default: begin
			end
		endcase
	end

	// Check and mark step: the target cell is entered when it is not yet marked
	// and, away from the seeds, is not lower than the cell being expanded.
	assign own_row = flood_q ? br_rd_q : tl_rd_q;
	assign own_bit = own_row[tgt_c_q];
	assign mark    = !own_bit && (seeding_q || (h_rd_q >= here_h_q));
	always_comb begin
		own_row_set          = own_row;
		own_row_set[tgt_c_q] = 1'b1;
	end

	always_comb begin
		mask_c = '0;
		for (int c = 0; c < MASK_N; c++) begin
			mask_c[c] = rd_ok_q && tl_rd_q[c] && br_rd_q[c];
		end
	end

	// Memories with registered reads.
	always_ff @(posedge clk) begin
		h_rd_q  <= height_mem[h_raddr];
		tl_rd_q <= tl_mem[vis_raddr];
		br_rd_q <= br_mem[vis_raddr];
		q_rd_q  <= queue_mem[head_q[ADDR_W-1:0]];
		if (take && item.opcode == tbfr_pkg::OP_LOAD && load_ok) begin
			height_mem[{ROW_W'(item.row), COL_W'(item.col)}] <= load_h;
		end
		if (state_q == S_CLEAR) begin
			tl_mem[clr_q] <= '0;
			br_mem[clr_q] <= '0;
		end
		if (state_q == S_CHK && mark) begin
			if (flood_q) begin
				br_mem[tgt_r_q] <= own_row_set;
			end else begin
				tl_mem[tgt_r_q] <= own_row_set;
			end
			queue_mem[tail_q[ADDR_W-1:0]] <= {tgt_r_q, tgt_c_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= CFG_W_L'(32);
			cols_cfg_q <= CFG_W_L'(32);
		end else if (cfg_valid) begin
			if (cfg_index == tbfr_pkg::CFG_ROWS) begin
				rows_cfg_q <= cfg_data;
			end else if (cfg_index == tbfr_pkg::CFG_COLS) begin
				cols_cfg_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HWAIT) begin
			here_h_q <= h_rd_q;
		end
		if (state_q == S_HERE) begin
			cur_r_q <= q_rd_q[ADDR_W-1:COL_W];
			cur_c_q <= q_rd_q[COL_W-1:0];
		end
		if (state_q == S_READ) begin
			mask_q <= mask_c;
		end else if (state_q == S_POP) begin
			mask_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			nr_q         <= '0;
			nc_q         <= '0;
			clr_q        <= '0;
			boot_q       <= 1'b1;
			flood_q      <= 1'b0;
			seeding_q    <= 1'b0;
			seed_phase_q <= 1'b0;
			seed_idx_q   <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			tgt_r_q      <= '0;
			tgt_c_q      <= '0;
			dir_q        <= '0;
			count_q      <= '0;
			rd_ok_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			// A word leaving the result port frees it, unless a new one is loaded.
			if (out_valid_q && !result_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						case (item.opcode)
							tbfr_pkg::OP_SOLVE: begin
								nr_q         <= nr_new;
								nc_q         <= nc_new;
								count_q      <= '0;
								clr_q        <= '0;
								flood_q      <= 1'b0;
								seed_phase_q <= 1'b0;
								seed_idx_q   <= '0;
								head_q       <= '0;
								tail_q       <= '0;
								state_q      <= S_CLEAR;
							end
							tbfr_pkg::OP_READ: begin
								rd_ok_q <= read_ok;
								state_q <= S_READ;
							end
							default: begin
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (32'(clr_q) == MAX_ROWS - 1) begin
						boot_q  <= 1'b0;
						state_q <= boot_q ? S_IDLE : S_SEED;
					end
				end
				S_SEED: begin
					if (!seed_phase_q && 32'(seed_idx_q) >= 32'(nc_q)) begin
						seed_phase_q <= 1'b1;
						seed_idx_q   <= '0;
					end else if (seed_phase_q && 32'(seed_idx_q) >= 32'(nr_q)) begin
						state_q <= S_POP;
					end else begin
						tgt_r_q    <= seed_r;
						tgt_c_q    <= seed_c;
						seeding_q  <= 1'b1;
						seed_idx_q <= seed_idx_q + SIDX_W'(1);
						state_q    <= S_CHK;
					end
				end
				S_CHK: begin
					if (mark) begin
						tail_q <= tail_q + (ADDR_W + 1)'(1);
						if (flood_q && tl_rd_q[tgt_c_q] && count_q != CNT_MAX) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					if (seeding_q) begin
						state_q <= S_SEED;
					end else if (dir_q == 2'd3) begin
						state_q <= S_POP;
					end else begin
						dir_q   <= dir_q + 2'd1;
						state_q <= S_NBR;
					end
				end
				S_POP: begin
					seeding_q <= 1'b0;
					if (head_q == tail_q) begin
						if (!flood_q) begin
							flood_q      <= 1'b1;
							seed_phase_q <= 1'b0;
							seed_idx_q   <= '0;
							head_q       <= '0;
							tail_q       <= '0;
							state_q      <= S_SEED;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						head_q  <= head_q + (ADDR_W + 1)'(1);
						state_q <= S_HERE;
					end
				end
				S_HERE: begin
					state_q <= S_HWAIT;
				end
				S_HWAIT: begin
					dir_q   <= '0;
					state_q <= S_NBR;
				end
				S_NBR: begin
					if (nbr_ok) begin
						tgt_r_q <= nbr_r;
						tgt_c_q <= nbr_c;
						state_q <= S_CHK;
					end else if (dir_q == 2'd3) begin
						state_q <= S_POP;
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.row_mask   <= mask_q;
						out_q.both_count <= count_q;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
